>>> hdl/xxh_pkg.sv
`default_nettype none
package xxh_pkg;
    localparam logic [63:0] P1 = 64'd11400714785074694791;
    localparam logic [63:0] P2 = 64'd14029467366897019727;
    localparam logic [63:0] P3 = 64'd1609587929392839161;
    localparam logic [63:0] P4 = 64'd9650029242287828579;
    localparam logic [63:0] P5 = 64'd2870177450012600261;
    localparam logic [63:0] SEED_RESET = 64'd0;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
        rotl = (x << r) | (x >> (64 - r));
    endfunction
endpackage
`default_nettype wire

>>> hdl/xxh_if.sv
`default_nettype none
interface xxh_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        is_last;
    modport source (output valid, data_word, byte_count, is_last, input ready);
    modport sink (input valid, data_word, byte_count, is_last, output ready);
endinterface

interface xxh_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest;
    modport source (output valid, digest, input ready);
    modport sink (input valid, digest, output ready);
endinterface

interface xxh_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] seed;
    modport source (output valid, seed, input ready);
    modport sink (input valid, seed, output ready);
endinterface
`default_nettype wire

>>> hdl/xxh_mul.sv
`default_nettype none
// 64x64 low-half multiply in three 32x32 partial products, one per cycle
module xxh_mul
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             done,
    output logic [63:0]      p
);
    logic [63:0] a_reg, b_reg, acc_reg;
    logic [1:0]  step_reg;
    logic        busy_reg, done_reg;
    logic [31:0] x, y;
    logic [63:0] pp;

    always_comb
    begin
        case (step_reg)
            2'd0:    begin x = a_reg[31:0];  y = b_reg[31:0];  end
            2'd1:    begin x = a_reg[63:32]; y = b_reg[31:0];  end
            2'd2:    begin x = a_reg[31:0];  y = b_reg[63:32]; end
            default: begin x = 32'd0;        y = 32'd0;        end
        endcase
        pp = 64'(x) * 64'(y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= 64'd0;
        end
        else if (busy_reg)
        begin
            if (step_reg == 2'd0)
                acc_reg <= pp;
            else
                acc_reg <= acc_reg + {pp[31:0], 32'd0};
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;
endmodule
`default_nettype wire

>>> hdl/xxh64_stream_hash_unit.sv
`default_nettype none
// Streaming XXH64 hasher. Message words (up to 8 little-endian bytes, first byte
// in bits 7:0) enter on in_ch; an item with is_last high produces one digest on
// out_ch. The seed register is sampled at the first word of each message. All
// multiplies go through one shared 64-bit multiplier built from 32x32 partial
// products. A word that is not last and does not fill a stripe leaves in_ch
// ready, so such words can follow back to back; the word completing a 32-byte
// stripe runs 8 multiplies and holds in_ch low until they are done. The last
// word adds lane merge (12 multiplies, only after a full stripe), tail folding
// (3 multiplies per 8-byte word, 2 per 4-byte word and 2 per byte) and
// avalanche (2); in_ch stays low from accept until the digest moves to the
// output register, which waits for out_ch to take the previous digest. The
// digest sits in its own output register, so the next message may start while
// it waits.
module xxh64_stream_hash_unit
    import xxh_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    xxh_cfg_if.sink    cfg_ch,
    xxh_in_if.sink     in_ch,
    xxh_out_if.source  out_ch
);
    typedef enum logic [4:0] {
        S_IDLE, S_STRIPE_A, S_STRIPE_B, S_LAST, S_MERGE_A, S_MERGE_B, S_MERGE_C,
        S_LEN, S_T8_A, S_T8_B, S_T8_C, S_T4_A, S_T4_B, S_T1_A, S_T1_B,
        S_AV_A, S_AV_B, S_AV_C, S_OUT
    } state_t;

    state_t      state_reg;
    logic [63:0] seed_reg, msg_seed_reg;
    logic [63:0] lane_reg [4];
    logic [63:0] stripe_reg [4];
    logic [5:0]  buffered_reg;
    logic [63:0] total_reg;
    logic        in_msg_reg, consumed_reg;
    logic        last_reg;
    logic [63:0] h_reg, w_reg, digest_reg;
    logic [1:0]  idx_reg;
    logic [2:0]  rem_reg;
    logic        wait_reg;
    logic        out_valid_reg;
    logic        out_load;

    logic        mul_start, mul_done;
    logic [63:0] mul_a, mul_b, mul_p;

    xxh_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    assign cfg_ch.ready  = 1'b1;
    assign in_ch.ready   = (state_reg == S_IDLE);
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.digest = digest_reg;

    // finished digest moves to the output register once it is free
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ch.ready);

    // incoming word, masked and counted
    logic [3:0]  n_eff;
    logic [63:0] word_m;
    always_comb
    begin
        n_eff = (!in_ch.is_last || in_ch.byte_count > 4'd8) ? 4'd8 : in_ch.byte_count;
        if (n_eff == 4'd8)
            word_m = in_ch.data_word;
        else
            word_m = in_ch.data_word & ((64'd1 << {n_eff[2:0], 3'd0}) - 64'd1);
    end

    logic [63:0] merge_sum;
    assign merge_sum = rotl(lane_reg[0], 1) + rotl(lane_reg[1], 7)
                     + rotl(lane_reg[2], 12) + rotl(lane_reg[3], 18);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seed_reg      <= SEED_RESET;
            msg_seed_reg  <= 64'd0;
            buffered_reg  <= 6'd0;
            total_reg     <= 64'd0;
            in_msg_reg    <= 1'b0;
            consumed_reg  <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            mul_start     <= 1'b0;
            mul_a         <= 64'd0;
            mul_b         <= 64'd0;
            h_reg         <= 64'd0;
            w_reg         <= 64'd0;
            digest_reg    <= 64'd0;
            wait_reg      <= 1'b0;
            idx_reg       <= 2'd0;
            rem_reg       <= 3'd0;
            for (int i = 0; i < 4; i++)
            begin
                lane_reg[i]   <= 64'd0;
                stripe_reg[i] <= 64'd0;
            end
        end
        else
        begin
            mul_start <= 1'b0;
            if (cfg_ch.valid)
                seed_reg <= cfg_ch.seed;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        logic [5:0]  b0;
                        logic [63:0] t0;
                        logic        c0;
                        b0 = in_msg_reg ? buffered_reg : 6'd0;
                        t0 = in_msg_reg ? total_reg : 64'd0;
                        c0 = in_msg_reg ? consumed_reg : 1'b0;
                        if (!in_msg_reg)
                        begin
                            msg_seed_reg <= seed_reg;
                            lane_reg[0]  <= seed_reg + P1 + P2;
                            lane_reg[1]  <= seed_reg + P2;
                            lane_reg[2]  <= seed_reg;
                            lane_reg[3]  <= seed_reg - P1;
                        end
                        in_msg_reg <= 1'b1;
                        last_reg   <= in_ch.is_last;
                        if (n_eff != 4'd0)
                        begin
                            stripe_reg[b0[4:3]] <= word_m;
                            b0 = b0 + 6'(n_eff);
                            t0 = t0 + 64'(n_eff);
                        end
                        buffered_reg <= b0;
                        total_reg    <= t0;
                        consumed_reg <= c0;
                        idx_reg      <= 2'd0;
                        if (b0 >= 6'd32)
                        begin
                            state_reg <= S_STRIPE_A;
                            wait_reg  <= 1'b0;
                        end
                        else if (in_ch.is_last)
                            state_reg <= S_LAST;
                    end
                end
                // lane round: acc += w*P2, rotl 31, *P1
                S_STRIPE_A:
                begin
                    if (!wait_reg)
                    begin
                        mul_a <= stripe_reg[idx_reg]; mul_b <= P2;
                        mul_start <= 1'b1; wait_reg <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        mul_a <= rotl(lane_reg[idx_reg] + mul_p, 31); mul_b <= P1;
                        mul_start <= 1'b1; state_reg <= S_STRIPE_B;
                    end
                end
                S_STRIPE_B:
                begin
                    if (mul_done)
                    begin
                        lane_reg[idx_reg] <= mul_p;
                        wait_reg <= 1'b0;
                        idx_reg  <= idx_reg + 2'd1;
                        if (idx_reg == 2'd3)
                        begin
                            buffered_reg <= 6'd0;
                            consumed_reg <= 1'b1;
                            state_reg    <= last_reg ? S_LAST : S_IDLE;
                        end
                        else
                            state_reg <= S_STRIPE_A;
                    end
                end
                S_LAST:
                begin
                    idx_reg  <= 2'd0;
                    wait_reg <= 1'b0;
                    if (consumed_reg)
                    begin
                        h_reg     <= merge_sum;
                        state_reg <= S_MERGE_A;
                    end
                    else
                    begin
                        h_reg     <= msg_seed_reg + P5;
                        state_reg <= S_LEN;
                    end
                end
                // fold lane: h ^= round(0,lane); h = h*P1+P4
                S_MERGE_A:
                begin
                    if (!wait_reg)
                    begin
                        mul_a <= lane_reg[idx_reg]; mul_b <= P2;
                        mul_start <= 1'b1; wait_reg <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        mul_a <= rotl(mul_p, 31); mul_b <= P1;
                        mul_start <= 1'b1; state_reg <= S_MERGE_B;
                    end
                end
                S_MERGE_B:
                begin
                    if (mul_done)
                    begin
                        mul_a <= h_reg ^ mul_p; mul_b <= P1;
                        mul_start <= 1'b1; state_reg <= S_MERGE_C;
                    end
                end
                S_MERGE_C:
                begin
                    if (mul_done)
                    begin
                        h_reg    <= mul_p + P4;
                        wait_reg <= 1'b0;
                        idx_reg  <= idx_reg + 2'd1;
                        state_reg <= (idx_reg == 2'd3) ? S_LEN : S_MERGE_A;
                    end
                end
                S_LEN:
                begin
                    h_reg    <= h_reg + total_reg;
                    idx_reg  <= 2'd0;
                    wait_reg <= 1'b0;
                    rem_reg  <= buffered_reg[2:0];
                    state_reg <= S_T8_A;
                end
                // full 8-byte tail words
                S_T8_A:
                begin
                    if (idx_reg == buffered_reg[4:3])
                    begin
                        w_reg <= stripe_reg[idx_reg];
                        state_reg <= (rem_reg >= 3'd4) ? S_T4_A :
                                     (rem_reg != 3'd0) ? S_T1_A : S_AV_A;
                    end
                    else if (!wait_reg)
                    begin
                        mul_a <= stripe_reg[idx_reg]; mul_b <= P2;
                        mul_start <= 1'b1; wait_reg <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        mul_a <= rotl(mul_p, 31); mul_b <= P1;
                        mul_start <= 1'b1; state_reg <= S_T8_B;
                    end
                end
                S_T8_B:
                begin
                    if (mul_done)
                    begin
                        mul_a <= rotl(h_reg ^ mul_p, 27); mul_b <= P1;
                        mul_start <= 1'b1; state_reg <= S_T8_C;
                    end
                end
                S_T8_C:
                begin
                    if (mul_done)
                    begin
                        h_reg    <= mul_p + P4;
                        wait_reg <= 1'b0;
                        idx_reg  <= idx_reg + 2'd1;
                        state_reg <= S_T8_A;
                    end
                end
                S_T4_A:
                begin
                    if (!wait_reg)
                    begin
                        mul_a <= {32'd0, w_reg[31:0]}; mul_b <= P1;
                        mul_start <= 1'b1; wait_reg <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        mul_a <= rotl(h_reg ^ mul_p, 23); mul_b <= P2;
                        mul_start <= 1'b1; state_reg <= S_T4_B;
                    end
                end
                S_T4_B:
                begin
                    if (mul_done)
                    begin
                        h_reg    <= mul_p + P3;
                        w_reg    <= w_reg >> 32;
                        rem_reg  <= rem_reg - 3'd4;
                        wait_reg <= 1'b0;
                        state_reg <= (rem_reg == 3'd4) ? S_AV_A : S_T1_A;
                    end
                end
                S_T1_A:
                begin
                    if (!wait_reg)
                    begin
                        mul_a <= {56'd0, w_reg[7:0]}; mul_b <= P5;
                        mul_start <= 1'b1; wait_reg <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        mul_a <= rotl(h_reg ^ mul_p, 11); mul_b <= P1;
                        mul_start <= 1'b1; state_reg <= S_T1_B;
                    end
                end
                S_T1_B:
                begin
                    if (mul_done)
                    begin
                        h_reg    <= mul_p;
                        w_reg    <= w_reg >> 8;
                        rem_reg  <= rem_reg - 3'd1;
                        wait_reg <= 1'b0;
                        state_reg <= (rem_reg == 3'd1) ? S_AV_A : S_T1_A;
                    end
                end
                S_AV_A:
                begin
                    mul_a <= h_reg ^ (h_reg >> 33); mul_b <= P2;
                    mul_start <= 1'b1; state_reg <= S_AV_B;
                end
                S_AV_B:
                begin
                    if (mul_done)
                    begin
                        mul_a <= mul_p ^ (mul_p >> 29); mul_b <= P3;
                        mul_start <= 1'b1; state_reg <= S_AV_C;
                    end
                end
                S_AV_C:
                begin
                    if (mul_done)
                    begin
                        h_reg     <= mul_p ^ (mul_p >> 32);
                        state_reg <= S_OUT;
                    end
                end
                // hold until the previous digest has been taken
                S_OUT:
                begin
                    if (out_load)
                    begin
                        digest_reg    <= h_reg;
                        buffered_reg  <= 6'd0;
                        total_reg     <= 64'd0;
                        consumed_reg  <= 1'b0;
                        in_msg_reg    <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
